FILE: src/rtb_pkg.sv
// rtb_pkg: shared constants, codes and types of the reload timer bank
// used by rtb_mem, rtb_scan and reload_timer_bank_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtb_pkg;

    // bank size; only the first sixteen can be addressed or scanned
    localparam int NUM_TIMERS = 16;
    localparam int SCAN_LIMIT = 16;
    localparam int DEPTH      = (NUM_TIMERS < SCAN_LIMIT) ? NUM_TIMERS : SCAN_LIMIT;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int IDX_W      = 4;   // timer_index / expired_index
    localparam int OP_W       = 2;
    localparam int CNT_W      = 5;   // timers_in_use
    localparam int DATA_W     = 32;  // counts
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 8;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_ARM    = 2'd1;
    localparam logic [OP_W-1:0] OP_DISARM = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EVAL  = 3'b010,
        ST_FLUSH = 3'b100
    } scan_state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              cnt_we;
        logic              rld_we;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] cnt_wdata;
        logic [DATA_W-1:0] rld_wdata;
    } mem_req_t;

    typedef struct packed {
        logic busy;
        logic pend_vld;
    } scan_status_t;

endpackage

`default_nettype wire

FILE: src/rtb_mem.sv
// rtb_mem: remaining-count and reload-count stores, one read port and one write port
// each, registered read data; depends on rtb_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtb_mem (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire rtb_pkg::mem_req_t         req,
    output logic [rtb_pkg::DATA_W-1:0]     cnt_rdata,
    output logic [rtb_pkg::DATA_W-1:0]     rld_rdata
);

    logic [rtb_pkg::DATA_W-1:0] cnt_mem [rtb_pkg::DEPTH];
    logic [rtb_pkg::DATA_W-1:0] rld_mem [rtb_pkg::DEPTH];
    logic [rtb_pkg::DEPTH-1:0]  cnt_vld_reg;
    logic [rtb_pkg::DEPTH-1:0]  rld_vld_reg;
    logic [rtb_pkg::DATA_W-1:0] cnt_rd_reg;
    logic [rtb_pkg::DATA_W-1:0] rld_rd_reg;
    logic                       cnt_rd_vld_reg;
    logic                       rld_rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.cnt_we)
        begin
            cnt_mem[req.wr_addr] <= req.cnt_wdata;
        end
        if (req.rld_we)
        begin
            rld_mem[req.wr_addr] <= req.rld_wdata;
        end
        if (req.rd_en)
        begin
            cnt_rd_reg <= cnt_mem[req.rd_addr];
            rld_rd_reg <= rld_mem[req.rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg    <= '0;
            rld_vld_reg    <= '0;
            cnt_rd_vld_reg <= 1'b0;
            rld_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.cnt_we)
            begin
                cnt_vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rld_we)
            begin
                rld_vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                cnt_rd_vld_reg <= cnt_vld_reg[req.rd_addr];
                rld_rd_vld_reg <= rld_vld_reg[req.rd_addr];
            end
        end
    end

    assign cnt_rdata = cnt_rd_vld_reg ? cnt_rd_reg : '0;
    assign rld_rdata = rld_rd_vld_reg ? rld_rd_reg : '0;

endmodule

`default_nettype wire

FILE: src/rtb_scan.sv
// rtb_scan: request decode, tick scan sequencer and result register
// drives rtb_mem through a mem_req_t; depends on rtb_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtb_scan (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [rtb_pkg::CNT_W-1:0]    timers_in_use,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [rtb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [rtb_pkg::OP_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [rtb_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                              m_axis_tlast,
    output rtb_pkg::mem_req_t                 mem_req,
    input  wire logic [rtb_pkg::DATA_W-1:0]   cnt_rdata,
    input  wire logic [rtb_pkg::DATA_W-1:0]   rld_rdata,
    output rtb_pkg::scan_status_t             status
);

    rtb_pkg::scan_state_t              state_reg, state_next;
    logic [rtb_pkg::ADDR_W-1:0]        ptr_reg, ptr_next;
    logic [rtb_pkg::CNT_W-1:0]         len_reg, len_next;
    logic                              pend_vld_reg, pend_vld_next;
    logic [rtb_pkg::ADDR_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                              out_vld_reg, out_vld_next;
    logic [rtb_pkg::IDX_W-1:0]         out_idx_reg, out_idx_next;
    logic                              out_last_reg, out_last_next;

    logic [rtb_pkg::IDX_W-1:0]         in_idx;
    logic [rtb_pkg::DATA_W-1:0]        in_timeout;
    logic [rtb_pkg::DATA_W-1:0]        in_reload;
    logic                              in_fire;
    logic                              in_range;
    logic [rtb_pkg::CNT_W-1:0]         scan_len;
    logic                              out_free;
    logic                              hit;
    logic                              expire;
    logic                              stall;
    logic                              last_entry;
    logic [rtb_pkg::DATA_W-1:0]        dec;

    assign in_idx     = s_axis_tdata[3:0];
    assign in_timeout = s_axis_tdata[35:4];
    assign in_reload  = s_axis_tdata[67:36];
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign in_range   = (32'(in_idx) < 32'(rtb_pkg::NUM_TIMERS));
    assign scan_len   = (32'(timers_in_use) > 32'(rtb_pkg::DEPTH))
                        ? rtb_pkg::CNT_W'(rtb_pkg::DEPTH) : timers_in_use;

    assign out_free   = !out_vld_reg || m_axis_tready;
    assign hit        = (cnt_rdata != '0);
    assign dec        = cnt_rdata - 32'd1;
    assign expire     = hit && (dec == '0);
    // a second expiry cannot displace the held one until the result register frees
    assign stall      = expire && pend_vld_reg && !out_free;
    assign last_entry = ((rtb_pkg::CNT_W'(ptr_reg) + rtb_pkg::CNT_W'(1)) == len_reg);

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        len_next      = len_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        out_vld_next  = out_vld_reg && !m_axis_tready;
        out_idx_next  = out_idx_reg;
        out_last_next = out_last_reg;
        mem_req           = '0;
        mem_req.wr_addr   = in_idx[rtb_pkg::ADDR_W-1:0];
        mem_req.cnt_wdata = in_timeout;
        mem_req.rld_wdata = in_reload;

        unique case (state_reg)
            rtb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (s_axis_tuser)
                        rtb_pkg::OP_TICK:
                        begin
                            if (scan_len != '0)
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = '0;
                                ptr_next        = '0;
                                len_next        = scan_len;
                                state_next      = rtb_pkg::ST_EVAL;
                            end
                        end
                        rtb_pkg::OP_ARM:
                        begin
                            mem_req.cnt_we = in_range;
                            mem_req.rld_we = in_range;
                        end
                        rtb_pkg::OP_DISARM:
                        begin
                            mem_req.cnt_we    = in_range;
                            mem_req.cnt_wdata = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rtb_pkg::ST_EVAL:
            begin
                if (!stall)
                begin
                    mem_req.wr_addr   = ptr_reg;
                    mem_req.cnt_we    = hit;
                    mem_req.cnt_wdata = expire ? rld_rdata : dec;
                    if (expire)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_vld_next  = 1'b1;
                            out_idx_next  = rtb_pkg::IDX_W'(pend_idx_reg);
                            out_last_next = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_idx_next = ptr_reg;
                    end
                    if (last_entry)
                    begin
                        state_next = rtb_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        ptr_next        = ptr_reg + rtb_pkg::ADDR_W'(1);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ptr_reg + rtb_pkg::ADDR_W'(1);
                    end
                end
            end
            rtb_pkg::ST_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = rtb_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_idx_next  = rtb_pkg::IDX_W'(pend_idx_reg);
                    out_last_next = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = rtb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rtb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rtb_pkg::ST_IDLE;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        len_reg      <= len_next;
        pend_idx_reg <= pend_idx_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    assign s_axis_tready   = (state_reg == rtb_pkg::ST_IDLE);
    assign m_axis_tvalid   = out_vld_reg;
    assign m_axis_tdata    = rtb_pkg::M_TDATA_W'(out_idx_reg);
    assign m_axis_tlast    = out_last_reg;
    assign status.busy     = (state_reg != rtb_pkg::ST_IDLE);
    assign status.pend_vld = pend_vld_reg;

endmodule

`default_nettype wire

FILE: src/reload_timer_bank_unit.sv
// reload_timer_bank_unit: top level of the reload timer bank
// holds the timers_in_use register, instantiates rtb_mem and rtb_scan; uses rtb_pkg
`timescale 1ns / 1ps
`default_nettype none

// usage
//   s_axis: one request per handshake; tuser carries the opcode (tick, arm, disarm),
//     tdata carries timer_index, timeout_value and reload_value
//   m_axis: one result per expired timer, lowest index first; tlast marks the
//     final expiry of a tick, and a tick with no expiry gives no result
//   cfg_wr_en / cfg_wr_data: write timers_in_use, only while the bank is idle
// timing
//   arm, disarm and unused opcodes do not leave idle; s_axis_tready is high again next
//   a tick scans the timers in index order: the sequencer does one read-modify-write
//   of the count store per cycle while not stalled, reading entry i+1 while writing
//   entry i, so the memory port sets the pace
//   the first result of a tick appears once a second expiry is found or the scan
//   ends, since the last-expiry flag is only known then
// stalls
//   a result waits in an output register while m_axis_tready is low; the scan
//   halts only when a further expiry needs that register, and nothing is lost
// reset
//   asynchronous, active low; all counts and reloads read as zero (per-entry valid
//   flags), timers_in_use returns to zero, no scan or result is outstanding

module reload_timer_bank_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration: timers_in_use
    input  wire logic                           cfg_wr_en,
    input  wire logic [rtb_pkg::CNT_W-1:0]      cfg_wr_data,
    // request channel
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // timer_index [3:0], timeout_value [35:4], reload_value [67:36], zero [71:68]
    input  wire logic [rtb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // opcode [1:0]
    input  wire logic [rtb_pkg::OP_W-1:0]       s_axis_tuser,
    // result channel
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // expired_index [3:0], zero [7:4]
    output logic [rtb_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // last_expiry
    output logic                                m_axis_tlast
);

    logic [rtb_pkg::CNT_W-1:0]  timers_in_use_reg;
    rtb_pkg::mem_req_t          mem_req;
    rtb_pkg::scan_status_t      status;
    logic [rtb_pkg::DATA_W-1:0] cnt_rdata;
    logic [rtb_pkg::DATA_W-1:0] rld_rdata;

    // scan length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timers_in_use_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            timers_in_use_reg <= cfg_wr_data;
        end
    end

    // count and reload stores
    rtb_mem u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mem_req),
        .cnt_rdata (cnt_rdata),
        .rld_rdata (rld_rdata)
    );

    // decode, scan sequencer and result register
    rtb_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .timers_in_use (timers_in_use_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mem_req       (mem_req),
        .cnt_rdata     (cnt_rdata),
        .rld_rdata     (rld_rdata),
        .status        (status)
    );

    // an arm, disarm or unused request leaves the bank ready on the next cycle
    a_short_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser != rtb_pkg::OP_TICK))
        |=> s_axis_tready)
        else $error("bank not ready after a non-tick request");

    // no expiry may be held back once the bank takes new requests
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !status.pend_vld)
        else $error("pending expiry left behind at end of tick");

    // a result not flagged last always has a later expiry held behind it
    a_not_last_has_more: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> status.pend_vld)
        else $error("non-final expiry with no further expiry held");

    // the scan length only changes while no tick is being scanned
    a_cfg_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |-> !status.busy)
        else $error("timers_in_use written during a tick");

endmodule

`default_nettype wire
